// ----- rtl/core/vfss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vfss_pkg;

    // Width of the interval step and its countdown
    localparam int INTERVAL_BITS = 16;

    // Register index width on the configuration channel
    localparam int REG_IDX_BITS = 2;

    // Register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_MODE     = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_INTERVAL = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_COUNT    = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SHEET    = 2'd3;

    // Analysis modes
    localparam int MODE_BITS = 2;
    localparam logic [MODE_BITS-1:0] MODE_EVERY  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TENTH  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CONFIG = 2'd2;

    // Fixed steps
    localparam logic [INTERVAL_BITS-1:0] STEP_ONE   = 16'd1;
    localparam logic [INTERVAL_BITS-1:0] STEP_TENTH = 16'd10;

    // Per-beat control shared by the selection units
    typedef struct packed {
        logic step;        // an input beat is taken this cycle
        logic clip_start;  // this beat is frame one of a clip
        logic active;      // frame lies within the source count
    } t_step_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/vfss_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input frame channel
interface vfss_in_if;
    logic valid;
    logic ready;
    logic first_frame;

    modport source (output valid, output first_frame, input ready);
    modport sink   (input valid, input first_frame, output ready);
endinterface

// Result channel
interface vfss_out_if #(
    parameter int COUNT_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] frame_number;
    logic                  keep;
    logic                  by_interval;
    logic                  by_sheet;
    logic                  beyond_count;

    modport source (output valid, output frame_number, output keep, output by_interval,
                    output by_sheet, output beyond_count, input ready);
    modport sink   (input valid, input frame_number, input keep, input by_interval,
                    input by_sheet, input beyond_count, output ready);
endinterface

// Configuration write channel
interface vfss_cfg_if #(
    parameter int DATA_BITS = 24
);
    logic                               valid;
    logic                               ready;
    logic [vfss_pkg::REG_IDX_BITS-1:0]  index;
    logic [DATA_BITS-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/video_frame_sample_selector_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Video frame sample selector.
// i_in carries one beat per source frame (first_frame marks frame one of a
// clip; a beat also starts a clip when no frame has been seen yet). o_out
// returns one beat per input beat: the one-based frame number and whether the
// frame is kept, by interval step / last frame or as a contact-sheet frame.
// i_cfg writes the four registers (mode, interval, source count, sheet count)
// by index; it is always ready and should be written only while idle.
// Latency: the result beat is valid the cycle after its input beat is taken.
// Throughput: one frame per cycle unless stalled; all selection is one pass
// of adds and compares between the state registers and the result register.
// When the receiver stalls, the result register holds and i_in.ready stays
// high only if that held result is being taken in the same cycle.
// Reset clears the frame position, accumulators and output valid, and sets
// the registers to mode every-frame, interval one, both counts zero.
module video_frame_sample_selector_core #(
    parameter int COUNT_BITS = 24,
    parameter int SHEET_BITS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    vfss_in_if.sink         i_in,
    vfss_out_if.source      o_out,
    vfss_cfg_if.sink        i_cfg
);

    localparam logic [COUNT_BITS-1:0] POS_MAX = '1;

    // Configuration registers
    logic [vfss_pkg::MODE_BITS-1:0]     r_mode;
    logic [vfss_pkg::INTERVAL_BITS-1:0] r_interval;
    logic [COUNT_BITS-1:0]              r_count;
    logic [SHEET_BITS-1:0]              r_sheet;

    logic                  r_valid;
    logic                  n_valid;
    logic [COUNT_BITS-1:0] r_pos;
    logic [COUNT_BITS-1:0] n_pos;
    logic [COUNT_BITS-1:0] r_number;
    logic                  r_by_interval;
    logic                  r_by_sheet;
    logic                  r_beyond;

    logic                  in_ready;
    logic                  accept;
    logic [COUNT_BITS-1:0] pos;
    logic [COUNT_BITS-1:0] number;
    logic                  beyond;
    logic                  last;
    logic                  int_hit;
    logic                  sheet_hit;
    vfss_pkg::t_step_ctl   ctl;

    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= vfss_pkg::MODE_EVERY;
            r_interval <= vfss_pkg::STEP_ONE;
            r_count    <= '0;
            r_sheet    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vfss_pkg::REG_MODE:     r_mode     <= i_cfg.data[vfss_pkg::MODE_BITS-1:0];
                vfss_pkg::REG_INTERVAL: r_interval <= i_cfg.data[vfss_pkg::INTERVAL_BITS-1:0];
                vfss_pkg::REG_COUNT:    r_count    <= i_cfg.data[COUNT_BITS-1:0];
                vfss_pkg::REG_SHEET:    r_sheet    <= i_cfg.data[SHEET_BITS-1:0];
                default:                r_mode     <= r_mode;
            endcase
        end
    end

    // Input handshake: free while the result slot empties this cycle
    assign in_ready   = !r_valid || o_out.ready;
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    // Frame numbering and count window
    always_comb begin
        pos            = i_in.first_frame ? '0 : r_pos;
        number         = (pos == POS_MAX) ? POS_MAX : pos + COUNT_BITS'(1);
        beyond         = (pos >= r_count);
        last           = (pos == r_count - COUNT_BITS'(1));
        ctl.step       = accept;
        ctl.clip_start = (pos == '0);
        ctl.active     = !beyond;
        n_pos          = accept ? number : r_pos;
    end

    vfss_interval u_interval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_mode     (r_mode),
        .i_interval (r_interval),
        .o_hit      (int_hit)
    );

    vfss_sheet #(
        .COUNT_BITS (COUNT_BITS),
        .SHEET_BITS (SHEET_BITS)
    ) u_sheet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_pos   (pos),
        .i_count (r_count),
        .i_sheet (r_sheet),
        .o_hit   (sheet_hit)
    );

    // Output beat slot
    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_number      <= number;
            r_by_interval <= !beyond && (int_hit || last);
            r_by_sheet    <= sheet_hit;
            r_beyond      <= beyond;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.frame_number = r_number;
    assign o_out.by_interval  = r_by_interval;
    assign o_out.by_sheet     = r_by_sheet;
    assign o_out.keep         = r_by_interval || r_by_sheet;
    assign o_out.beyond_count = r_beyond;

    // A taken frame always produces a result beat next cycle
    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted frame produced no result beat");

    // Frames past the count are never selected
    a_beyond_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_beyond |-> !r_by_interval && !r_by_sheet)
        else $error("frame beyond count marked as kept");

    // A clip restart numbers the frame as one
    a_restart_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.first_frame |=> r_number == COUNT_BITS'(1))
        else $error("restarted clip not numbered from one");

endmodule

`default_nettype wire

// ----- rtl/core/vfss_interval.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Interval step: counts down frames to the next interval frame
module vfss_interval (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire vfss_pkg::t_step_ctl              i_ctl,
    input  wire [vfss_pkg::MODE_BITS-1:0]         i_mode,
    input  wire [vfss_pkg::INTERVAL_BITS-1:0]     i_interval,
    output logic                                  o_hit
);

    logic [vfss_pkg::INTERVAL_BITS-1:0] r_countdown;
    logic [vfss_pkg::INTERVAL_BITS-1:0] n_countdown;
    logic [vfss_pkg::INTERVAL_BITS-1:0] step;
    logic [vfss_pkg::INTERVAL_BITS-1:0] cur;

    // Step from mode; unused mode behaves as configured
    always_comb begin
        case (i_mode)
            vfss_pkg::MODE_EVERY: step = vfss_pkg::STEP_ONE;
            vfss_pkg::MODE_TENTH: step = vfss_pkg::STEP_TENTH;
            default:              step = (i_interval == '0) ? vfss_pkg::STEP_ONE : i_interval;
        endcase
    end

    // Countdown restarts at clip start, holds past the count
    always_comb begin
        cur         = i_ctl.clip_start ? '0 : r_countdown;
        o_hit       = 1'b0;
        n_countdown = cur;
        if (i_ctl.active) begin
            if (cur == '0) begin
                o_hit       = 1'b1;
                n_countdown = step - vfss_pkg::STEP_ONE;
            end else begin
                n_countdown = cur - vfss_pkg::STEP_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
        end else if (i_ctl.step) begin
            r_countdown <= n_countdown;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/vfss_sheet.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Contact-sheet selection: evenly spaced frames tracked by running sums
module vfss_sheet #(
    parameter int COUNT_BITS = 24,
    parameter int SHEET_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire vfss_pkg::t_step_ctl  i_ctl,
    input  wire [COUNT_BITS-1:0]      i_pos,
    input  wire [COUNT_BITS-1:0]      i_count,
    input  wire [SHEET_BITS-1:0]      i_sheet,
    output logic                      o_hit
);

    localparam int ACC_BITS = COUNT_BITS + SHEET_BITS;
    localparam int CMP_BITS = (COUNT_BITS > SHEET_BITS) ? COUNT_BITS : SHEET_BITS;

    logic [SHEET_BITS-1:0] r_index;
    logic [ACC_BITS-1:0]   r_numer;
    logic [ACC_BITS-1:0]   r_ptd;
    logic [SHEET_BITS-1:0] n_index;
    logic [ACC_BITS-1:0]   n_numer;
    logic [ACC_BITS-1:0]   n_ptd;

    logic [SHEET_BITS-1:0] target;
    logic [SHEET_BITS-1:0] denom;
    logic [SHEET_BITS-1:0] cur_index;
    logic [ACC_BITS-1:0]   cur_numer;
    logic [ACC_BITS-1:0]   cur_ptd;
    logic [ACC_BITS-1:0]   ptd_next;
    logic [COUNT_BITS-1:0] count_m1;

    // Sheet target is the lesser of sheet count and source count
    always_comb begin
        if (CMP_BITS'(i_sheet) < CMP_BITS'(i_count)) begin
            target = i_sheet;
        end else begin
            target = SHEET_BITS'(i_count);
        end
        denom    = (target != '0) ? target - SHEET_BITS'(1) : '0;
        count_m1 = i_count - COUNT_BITS'(1);
    end

    // Accumulators reload at clip start
    always_comb begin
        cur_index = i_ctl.clip_start ? '0 : r_index;
        cur_numer = i_ctl.clip_start ? ACC_BITS'(denom >> 1) : r_numer;
        cur_ptd   = i_ctl.clip_start ? '0 : r_ptd;
        ptd_next  = cur_ptd + ACC_BITS'(denom);
    end

    // Selection and accumulator advance
    always_comb begin
        o_hit   = 1'b0;
        n_index = cur_index;
        n_numer = cur_numer;
        n_ptd   = cur_ptd;
        if (i_ctl.active) begin
            if (target == SHEET_BITS'(1)) begin
                // single sheet frame: only frame one
                o_hit = (i_pos == '0);
            end else if (target != '0 && cur_index < target) begin
                if (cur_numer < ptd_next) begin
                    o_hit   = 1'b1;
                    n_index = cur_index + SHEET_BITS'(1);
                    n_numer = cur_numer + ACC_BITS'(count_m1);
                end
            end
            n_ptd = ptd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_numer <= '0;
            r_ptd   <= '0;
        end else if (i_ctl.step) begin
            r_index <= n_index;
            r_numer <= n_numer;
            r_ptd   <= n_ptd;
        end
    end

endmodule

`default_nettype wire

// ----- tb/video_frame_sample_selector_core_tb.sv -----
`timescale 1ns / 1ps

module video_frame_sample_selector_core_tb;
    import vfss_pkg::*;

    localparam int COUNT_BITS = 24;
    localparam int SHEET_BITS = 16;
    localparam int IDLE_LIMIT = 2000;

    localparam logic [63:0] COUNT_MAX  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] SHEET_MASK = (64'd1 << SHEET_BITS) - 64'd1;
    localparam logic [63:0] ACC_MASK   = (64'd1 << (COUNT_BITS + SHEET_BITS)) - 64'd1;
    localparam logic [63:0] STEP_MASK  = (64'd1 << INTERVAL_BITS) - 64'd1;

    // Mode code left spare by the package; behaves as the configured interval
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [COUNT_BITS-1:0] frame_number;
        logic                  keep;
        logic                  by_interval;
        logic                  by_sheet;
        logic                  beyond_count;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    vfss_in_if                               in_if ();
    vfss_out_if #(.COUNT_BITS(COUNT_BITS))   out_if ();
    vfss_cfg_if #(.DATA_BITS(COUNT_BITS))    cfg_if ();

    video_frame_sample_selector_core #(
        .COUNT_BITS(COUNT_BITS),
        .SHEET_BITS(SHEET_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Register copies
    logic [MODE_BITS-1:0] sel_mode;
    logic [63:0]          sel_interval;
    logic [63:0]          sel_count;
    logic [63:0]          sel_sheet;

    // Selector state copies
    logic [63:0] next_pos;
    logic [63:0] step_left;
    logic [63:0] sheet_taken;
    logic [63:0] sheet_acc;
    logic [63:0] pos_acc;

    t_frame_result pending_selections[$];

    bit source_idle;
    bit sink_idle;
    int mismatches;
    int results_checked;
    int frames_sent;
    int clips_started;
    int reg_writes;
    int kept_seen;
    int sheet_seen;
    int beyond_seen;
    int idle_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Works out the selection for one frame and advances the state copies
    function automatic t_frame_result select_frame(input logic first);
        t_frame_result res;
        logic [63:0]   pos;
        logic [63:0]   tgt;
        logic [63:0]   denom;
        logic [63:0]   step;
        logic [63:0]   number;
        pos   = next_pos;
        tgt   = (sel_sheet < sel_count) ? sel_sheet : sel_count;
        denom = (tgt > 64'd0) ? tgt - 64'd1 : 64'd0;
        case (sel_mode)
            MODE_EVERY: step = 64'(STEP_ONE);
            MODE_TENTH: step = 64'(STEP_TENTH);
            default:    step = (sel_interval == 64'd0) ? 64'(STEP_ONE) : sel_interval;
        endcase
        res = '0;

        // clip start reloads the accumulators from the current registers
        if (first)
            pos = 64'd0;
        if (pos == 64'd0) begin
            step_left   = 64'd0;
            sheet_taken = 64'd0;
            sheet_acc   = (denom >> 1) & ACC_MASK;
            pos_acc     = 64'd0;
        end

        number           = (pos >= COUNT_MAX) ? COUNT_MAX : pos + 64'd1;
        res.frame_number = number[COUNT_BITS-1:0];
        res.beyond_count = (pos >= sel_count);

        if (!res.beyond_count) begin
            // interval step and last frame
            if (step_left == 64'd0) begin
                res.by_interval = 1'b1;
                step_left       = (step - 64'd1) & STEP_MASK;
            end else begin
                step_left = (step_left - 64'd1) & STEP_MASK;
            end
            if (pos == sel_count - 64'd1)
                res.by_interval = 1'b1;

            // contact sheet
            if (tgt == 64'd1) begin
                res.by_sheet = (pos == 64'd0);
            end else if (tgt > 64'd1 && sheet_taken < tgt) begin
                if (sheet_acc < ((pos_acc + denom) & ACC_MASK)) begin
                    res.by_sheet = 1'b1;
                    sheet_taken  = (sheet_taken + 64'd1) & SHEET_MASK;
                    sheet_acc    = (sheet_acc + (sel_count - 64'd1)) & ACC_MASK;
                end
            end
            pos_acc = (pos_acc + denom) & ACC_MASK;
        end

        res.keep = res.by_interval | res.by_sheet;
        next_pos = (pos >= COUNT_MAX) ? COUNT_MAX : pos + 64'd1;
        return res;
    endfunction

    function automatic void apply_register(input logic [REG_IDX_BITS-1:0] idx,
                                           input logic [COUNT_BITS-1:0] value);
        case (idx)
            REG_MODE:     sel_mode     = value[MODE_BITS-1:0];
            REG_INTERVAL: sel_interval = 64'(value) & STEP_MASK;
            REG_COUNT:    sel_count    = 64'(value) & COUNT_MAX;
            REG_SHEET:    sel_sheet    = 64'(value) & SHEET_MASK;
            default:      ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
                 $time, results_checked, what, got, want);
    endtask

    // Sender pauses until every outstanding result is back
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (pending_selections.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes all four registers, one beat each, while the block is idle
    task automatic write_registers(input logic [COUNT_BITS-1:0] mode_data,
                                   input logic [COUNT_BITS-1:0] interval_data,
                                   input logic [COUNT_BITS-1:0] count_data,
                                   input logic [COUNT_BITS-1:0] sheet_data);
        logic [REG_IDX_BITS-1:0] idx_list [4];
        logic [COUNT_BITS-1:0]   val_list [4];
        int i;
        idx_list = '{REG_MODE, REG_INTERVAL, REG_COUNT, REG_SHEET};
        val_list = '{mode_data, interval_data, count_data, sheet_data};
        wait_for_drain();
        for (i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx_list[i];
            cfg_if.data  <= val_list[i];
            do @(posedge i_clk); while (!cfg_if.ready);
            apply_register(idx_list[i], val_list[i]);
            reg_writes++;
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Sends one frame beat; valid stays high after the beat is taken
    task automatic send_frame(input logic first);
        int gap;
        if (source_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.first_frame <= first;
        do @(posedge i_clk); while (!in_if.ready);
        pending_selections.push_back(select_frame(first));
        frames_sent++;
        if (first)
            clips_started++;
    endtask

    // Random register set, biased towards short clips
    function automatic void pick_registers(output logic [COUNT_BITS-1:0] mode_data,
                                           output logic [COUNT_BITS-1:0] interval_data,
                                           output logic [COUNT_BITS-1:0] count_data,
                                           output logic [COUNT_BITS-1:0] sheet_data);
        logic [15:0] step;
        logic [15:0] sheet;
        int          cnt;
        int          r;
        mode_data = {22'($urandom), 2'($urandom_range(0, 3))};

        r = $urandom_range(0, 9);
        if (r == 0)
            step = 16'd0;
        else if (r == 1)
            step = 16'hFFFF;
        else
            step = 16'($urandom_range(1, 12));
        interval_data = {8'($urandom), step};

        r = $urandom_range(0, 9);
        if (r == 0)
            cnt = 0;
        else if (r == 1)
            cnt = $urandom_range(1000, 16777215);
        else
            cnt = $urandom_range(1, 40);
        count_data = 24'(cnt);

        r = $urandom_range(0, 9);
        if (r == 0)
            sheet = 16'd0;
        else if (r == 1)
            sheet = 16'd1;
        else if (r == 2)
            sheet = 16'hFFFF;
        else if (r == 3)
            sheet = 16'($urandom_range(0, 65535));
        else
            sheet = 16'($urandom_range(0, ((cnt > 60) ? 60 : cnt) + 4));
        sheet_data = {8'($urandom), sheet};
    endfunction

    // Clips of random setup: mostly whole clips, with stray restarts,
    // clips that carry on from the last one and registers changed mid-clip
    task automatic run_clips(input int frame_goal);
        logic [COUNT_BITS-1:0] mode_d;
        logic [COUNT_BITS-1:0] step_d;
        logic [COUNT_BITS-1:0] cnt_d;
        logic [COUNT_BITS-1:0] sheet_d;
        int clip_len;
        int i;
        while (frames_sent < frame_goal) begin
            pick_registers(mode_d, step_d, cnt_d, sheet_d);
            write_registers(mode_d, step_d, cnt_d, sheet_d);
            clip_len = (cnt_d > 60) ? 60 : int'(cnt_d);
            clip_len += $urandom_range(0, 3);
            for (i = 0; i < clip_len; i++) begin
                if (i == clip_len / 2 && $urandom_range(0, 7) == 0) begin
                    pick_registers(mode_d, step_d, cnt_d, sheet_d);
                    write_registers(mode_d, step_d, cnt_d, sheet_d);
                end
                if (i == 0)
                    send_frame($urandom_range(0, 9) != 0);
                else
                    send_frame($urandom_range(0, 39) == 0);
            end
        end
    endtask

    // Reset register values: count zero, so nothing is kept
    task automatic test_reset_state();
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    // Every tenth frame with three sheet frames over a twelve-frame clip
    task automatic test_tenth_mode_with_sheet();
        int i;
        write_registers(24'(MODE_TENTH), 24'd0, 24'd12, 24'd3);
        for (i = 0; i < 13; i++)
            send_frame(i == 0);
    endtask

    // Largest interval, count and sheet, with spare bits set in the mode, interval and sheet writes
    task automatic test_register_extremes();
        int i;
        write_registers({22'h3FFFFF, MODE_CONFIG}, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        for (i = 0; i < 4; i++)
            send_frame(i == 0);
    endtask

    // Spare mode with zero interval, one sheet frame, then new values mid-clip
    task automatic test_single_sheet_and_midclip_change();
        int i;
        write_registers(24'(MODE_SPARE), 24'd0, 24'd3, 24'd1);
        for (i = 0; i < 3; i++)
            send_frame(i == 0);
        write_registers(24'(MODE_EVERY), 24'd5, 24'd6, 24'd4);
        send_frame(1'b0);
        send_frame(1'b0);
    endtask

    task automatic test_random_clips();
        run_clips(520);
    endtask

    task automatic test_back_to_back_clips();
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        run_clips(650);
    endtask

    // Receiver stalls in random bursts
    initial begin : sink_stalls
        int stall_left;
        stall_left   = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!sink_idle) begin
                stall_left = 0;
                out_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    out_if.ready <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Result checker: each beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_selections.size() == 0) begin
                report_mismatch("unexpected beat", 64'(out_if.frame_number), 64'd0);
            end else begin
                want = pending_selections.pop_front();
                if (out_if.frame_number !== want.frame_number)
                    report_mismatch("frame_number", 64'(out_if.frame_number),
                                    64'(want.frame_number));
                if (out_if.keep !== want.keep)
                    report_mismatch("keep", 64'(out_if.keep), 64'(want.keep));
                if (out_if.by_interval !== want.by_interval)
                    report_mismatch("by_interval", 64'(out_if.by_interval),
                                    64'(want.by_interval));
                if (out_if.by_sheet !== want.by_sheet)
                    report_mismatch("by_sheet", 64'(out_if.by_sheet), 64'(want.by_sheet));
                if (out_if.beyond_count !== want.beyond_count)
                    report_mismatch("beyond_count", 64'(out_if.beyond_count),
                                    64'(want.beyond_count));
                kept_seen   += want.keep;
                sheet_seen  += want.by_sheet;
                beyond_seen += want.beyond_count;
            end
            results_checked++;
        end
    end

    // Watchdog: too long without any beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        sel_mode     = MODE_EVERY;
        sel_interval = 64'(STEP_ONE);
        sel_count    = 64'd0;
        sel_sheet    = 64'd0;
        next_pos     = 64'd0;
        step_left    = 64'd0;
        sheet_taken  = 64'd0;
        sheet_acc    = 64'd0;
        pos_acc      = 64'd0;
        source_idle  = 1'b1;
        sink_idle    = 1'b1;
        idle_cycles  = 0;

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.first_frame <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_MODE;
        cfg_if.data       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_tenth_mode_with_sheet();
        test_register_extremes();
        test_single_sheet_and_midclip_change();
        test_random_clips();
        test_back_to_back_clips();

        // drain, then idle to catch any stray beat
        in_if.valid <= 1'b0;
        while (pending_selections.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Covered %0d frames in %0d restarted clips, %0d register writes",
                 frames_sent, clips_started, reg_writes);
        $display("%0d results checked: %0d kept, %0d sheet frames, %0d beyond the count",
                 results_checked, kept_seen, sheet_seen, beyond_seen);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
